>>> rtl/kti_pkg.sv
package kti_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    localparam int CFG_W    = 7;
    localparam int SLOT_W   = 6;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int STAT_W   = 2;
    localparam int NCOMP    = 3;
    localparam int KEY_W    = DATA_W * (NCOMP + 1);
    localparam int PROD_W   = DATA_W + FRAC_W + 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_PAST   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BEFORE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SRCH,
        S_DIV,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    typedef logic signed [DATA_W-1:0] t_vec [NCOMP];

endpackage

>>> rtl/kti_ram.sv
module kti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/keyframe_track_interpolator.sv
// A query reads the first key, runs a linear search that steps over 0..62
// keys, then the restoring divider and a multiply and add per component,
// with early exits for one key, before first key and past last key.
// Throughput: one word at a time, set by the one-port key RAM search, the
// 16-step restoring divider and the shared multiplier.
// Reset (synchronous, active low) clears control and sets key_count to 1.
module keyframe_track_interpolator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [kti_pkg::CFG_W-1:0]              i_cfg_key_count,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_command,
    input  logic [kti_pkg::SLOT_W-1:0]             i_key_slot,
    input  logic [kti_pkg::DATA_W-1:0]             i_key_time,
    input  logic signed [kti_pkg::DATA_W-1:0]      i_key_x,
    input  logic signed [kti_pkg::DATA_W-1:0]      i_key_y,
    input  logic signed [kti_pkg::DATA_W-1:0]      i_key_z,
    input  logic [kti_pkg::DATA_W-1:0]             i_query_time,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [kti_pkg::DATA_W-1:0]      o_out_x,
    output logic signed [kti_pkg::DATA_W-1:0]      o_out_y,
    output logic signed [kti_pkg::DATA_W-1:0]      o_out_z,
    output logic [kti_pkg::SLOT_W-1:0]             o_segment,
    output logic [kti_pkg::STAT_W-1:0]             o_status
);
    import kti_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_key_count, n_key_count;
    logic              r_out_valid, n_out_valid;

    logic [DATA_W-1:0] r_q, n_q;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [KEY_AW-1:0] r_idx, n_idx;
    logic [DATA_W-1:0] r_t0, n_t0;
    logic [DATA_W-1:0] r_div, n_div;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [FRAC_W-1:0] r_quo, n_quo;
    logic [3:0]        r_cnt, n_cnt;
    logic [1:0]        r_comp, n_comp;
    t_vec              r_v0, n_v0;
    t_vec              r_v1, n_v1;
    t_vec              r_res, n_res;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [SLOT_W-1:0] r_seg, n_seg;
    logic [STAT_W-1:0] r_stat, n_stat;

    logic signed [DATA_W-1:0] r_o_x, r_o_y, r_o_z, n_o_x, n_o_y, n_o_z;
    logic [SLOT_W-1:0] r_o_seg, n_o_seg;
    logic [STAT_W-1:0] r_o_stat, n_o_stat;

    logic              in_acc;
    logic              ram_we;
    logic [KEY_AW-1:0] ram_addr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;
    logic [DATA_W-1:0] rd_time;
    t_vec              rd_vec;
    logic [CNT_W-1:0]  n_clamp;
    logic              out_load;
    logic [DATA_W:0]   rem_sh;
    logic              div_ge;
    logic signed [DATA_W:0] diff;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_load    = (r_state == S_DONE) & (~r_out_valid | i_out_ready);

    assign rd_vec[0] = ram_rdata[DATA_W-1:0];
    assign rd_vec[1] = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_vec[2] = ram_rdata[3*DATA_W-1:2*DATA_W];
    assign rd_time   = ram_rdata[4*DATA_W-1:3*DATA_W];
    assign ram_wdata = {i_key_time, i_key_z, i_key_y, i_key_x};

    always_comb begin
        if (r_key_count == '0) begin
            n_clamp = CNT_W'(1);
        end else if (int'(r_key_count) > MAX_KEYS) begin
            n_clamp = CNT_W'(MAX_KEYS);
        end else begin
            n_clamp = CNT_W'(r_key_count);
        end
    end

    assign rem_sh = {r_rem, 1'b0};
    assign div_ge = (rem_sh >= {1'b0, r_div});
    assign diff   = {r_v1[r_comp][DATA_W-1], r_v1[r_comp]}
                  - {r_v0[r_comp][DATA_W-1], r_v0[r_comp]};

    kti_ram #(
        .WIDTH(KEY_W),
        .DEPTH(MAX_KEYS)
    ) u_keys (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_command == CMD_QUERY) ? S_FIRST : S_DONE;
                end
            end
            S_FIRST: begin
                if (r_n == CNT_W'(1) || r_q < rd_time) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_q < rd_time) begin
                    n_state = S_DIV;
                end else if (CNT_W'(r_idx) + CNT_W'(2) >= r_n) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (r_cnt == 4'd15) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = (r_comp == 2'd2) ? S_DONE : S_MUL;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_key_count = r_key_count;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_q      = r_q;
        n_n      = r_n;
        n_idx    = r_idx;
        n_t0     = r_t0;
        n_div    = r_div;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_comp   = r_comp;
        n_v0     = r_v0;
        n_v1     = r_v1;
        n_res    = r_res;
        n_prod   = r_prod;
        n_seg    = r_seg;
        n_stat   = r_stat;
        n_o_x    = r_o_x;
        n_o_y    = r_o_y;
        n_o_z    = r_o_z;
        n_o_seg  = r_o_seg;
        n_o_stat = r_o_stat;
        ram_we   = 1'b0;
        ram_addr = '0;

        if (i_cfg_valid) begin
            n_key_count = i_cfg_key_count;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_q = i_query_time;
                    n_n = n_clamp;
                    if (i_command == CMD_WRITE) begin
                        ram_addr = KEY_AW'(i_key_slot);
                        ram_we   = (CNT_W'(i_key_slot) < CNT_W'(MAX_KEYS));
                        n_res    = '{default: '0};
                        n_seg    = '0;
                        n_stat   = ST_OK;
                    end
                end
            end
            S_FIRST: begin
                n_res  = rd_vec;
                n_seg  = '0;
                n_stat = (r_n == CNT_W'(1)) ? ST_OK
                       : (r_q < rd_time)    ? ST_BEFORE : ST_OK;
                n_t0   = rd_time;
                n_v0   = rd_vec;
                n_idx  = '0;
                ram_addr = KEY_AW'(1);
            end
            S_SRCH: begin
                if (r_q < rd_time) begin
                    n_v1  = rd_vec;
                    n_div = rd_time - r_t0;
                    n_rem = r_q - r_t0;
                    n_quo = '0;
                    n_cnt = '0;
                end else if (CNT_W'(r_idx) + CNT_W'(2) >= r_n) begin
                    n_res  = rd_vec;
                    n_seg  = SLOT_W'(r_idx + KEY_AW'(1));
                    n_stat = ST_PAST;
                end else begin
                    n_t0     = rd_time;
                    n_v0     = rd_vec;
                    n_idx    = r_idx + KEY_AW'(1);
                    ram_addr = r_idx + KEY_AW'(2);
                end
            end
            S_DIV: begin
                // restoring step, one quotient bit a cycle
                n_rem  = div_ge ? DATA_W'(rem_sh - {1'b0, r_div}) : rem_sh[DATA_W-1:0];
                n_quo  = {r_quo[FRAC_W-2:0], div_ge};
                n_cnt  = r_cnt + 4'd1;
                n_comp = '0;
            end
            S_MUL: begin
                n_prod = PROD_W'(diff * $signed({1'b0, r_quo}));
            end
            S_ADD: begin
                n_res[r_comp] = r_v0[r_comp] + r_prod[DATA_W+FRAC_W-1:FRAC_W];
                n_comp = r_comp + 2'd1;
                n_seg  = SLOT_W'(r_idx);
                n_stat = ST_OK;
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_o_x    = r_res[0];
                    n_o_y    = r_res[1];
                    n_o_z    = r_res[2];
                    n_o_seg  = r_seg;
                    n_o_stat = r_stat;
                end
            end
            default: begin
                n_out_valid = r_out_valid & ~i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_key_count <= CFG_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_key_count <= n_key_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_t0     <= n_t0;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_comp   <= n_comp;
        r_v0     <= n_v0;
        r_v1     <= n_v1;
        r_res    <= n_res;
        r_prod   <= n_prod;
        r_seg    <= n_seg;
        r_stat   <= n_stat;
        r_o_x    <= n_o_x;
        r_o_y    <= n_o_y;
        r_o_z    <= n_o_z;
        r_o_seg  <= n_o_seg;
        r_o_stat <= n_o_stat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_o_x;
    assign o_out_y     = r_o_y;
    assign o_out_z     = r_o_z;
    assign o_segment   = r_o_seg;
    assign o_status    = r_o_stat;

endmodule

>>> verif/tb.sv
module tb;
    import kti_pkg::*;

    typedef struct {
        logic                     command;
        logic [SLOT_W-1:0]        key_slot;
        logic [DATA_W-1:0]        key_time;
        logic signed [DATA_W-1:0] key_x;
        logic signed [DATA_W-1:0] key_y;
        logic signed [DATA_W-1:0] key_z;
        logic [DATA_W-1:0]        query_time;
    } t_cmd_word;

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic [SLOT_W-1:0]        segment;
        logic [STAT_W-1:0]        status;
    } t_sample;

    class track_checker;
        logic [DATA_W-1:0]        time_mem [MAX_KEYS];
        logic signed [DATA_W-1:0] x_mem [MAX_KEYS];
        logic signed [DATA_W-1:0] y_mem [MAX_KEYS];
        logic signed [DATA_W-1:0] z_mem [MAX_KEYS];
        logic [CFG_W-1:0]         key_count;
        t_sample                  owed_samples [$];
        int                       failures;

        function new();
            key_count = 1;
            failures = 0;
            foreach (time_mem[k]) begin
                time_mem[k] = '0;
                x_mem[k] = '0;
                y_mem[k] = '0;
                z_mem[k] = '0;
            end
        endfunction

        function int keys_in_use();
            if (key_count == 0) return 1;
            if (key_count > MAX_KEYS) return MAX_KEYS;
            return key_count;
        endfunction

        // a + floor((b - a) * f / 2^16)
        function logic signed [DATA_W-1:0] blend_component(logic signed [DATA_W-1:0] a,
                                                          logic signed [DATA_W-1:0] b,
                                                          logic [FRAC_W-1:0] f);
            longint d;
            longint p;
            longint s;
            d = longint'(b) - longint'(a);
            p = d * longint'(f);
            s = longint'(a) + (p >>> FRAC_W);
            return s[DATA_W-1:0];
        endfunction

        function void take_key(int k, int seg, logic [STAT_W-1:0] st, ref t_sample s);
            s.x = x_mem[k];
            s.y = y_mem[k];
            s.z = z_mem[k];
            s.segment = seg[SLOT_W-1:0];
            s.status = st;
        endfunction

        function void note_command(t_cmd_word w);
            t_sample s;
            int n;
            int i;
            logic [63:0] num;
            logic [63:0] quot;
            logic [DATA_W-1:0] span;
            logic [FRAC_W-1:0] f;
            s = '{default: '0};
            if (w.command == CMD_WRITE) begin
                time_mem[w.key_slot] = w.key_time;
                x_mem[w.key_slot] = w.key_x;
                y_mem[w.key_slot] = w.key_y;
                z_mem[w.key_slot] = w.key_z;
            end else begin
                n = keys_in_use();
                if (n == 1) begin
                    take_key(0, 0, ST_OK, s);
                end else if (w.query_time < time_mem[0]) begin
                    take_key(0, 0, ST_BEFORE, s);
                end else begin
                    i = 0;
                    while (i + 1 < n && !(w.query_time < time_mem[i+1])) i++;
                    if (i + 1 >= n) begin
                        take_key(n - 1, n - 1, ST_PAST, s);
                    end else begin
                        num = {32'd0, w.query_time - time_mem[i]} << FRAC_W;
                        span = time_mem[i+1] - time_mem[i];
                        quot = num / {32'd0, span};
                        f = (quot > 64'hFFFF) ? 16'hFFFF : quot[FRAC_W-1:0];
                        s.x = blend_component(x_mem[i], x_mem[i+1], f);
                        s.y = blend_component(y_mem[i], y_mem[i+1], f);
                        s.z = blend_component(z_mem[i], z_mem[i+1], f);
                        s.segment = i[SLOT_W-1:0];
                        s.status = ST_OK;
                    end
                end
            end
            owed_samples.insert(owed_samples.size(), s);
        endfunction

        function void check_sample(t_sample got);
            t_sample e;
            if (owed_samples.size() == 0) begin
                $error("result word with nothing outstanding");
                failures++;
                return;
            end
            e = owed_samples.pop_front();
            if (got.x !== e.x) begin
                $error("out_x: expected %0d, got %0d", e.x, got.x);
                failures++;
            end
            if (got.y !== e.y) begin
                $error("out_y: expected %0d, got %0d", e.y, got.y);
                failures++;
            end
            if (got.z !== e.z) begin
                $error("out_z: expected %0d, got %0d", e.z, got.z);
                failures++;
            end
            if (got.segment !== e.segment) begin
                $error("segment: expected %0d, got %0d", e.segment, got.segment);
                failures++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                failures++;
            end
        endfunction
    endclass

    localparam int ITEMS_PER_PHASE = 130;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_key_count = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     command = CMD_WRITE;
    logic [SLOT_W-1:0]        key_slot = '0;
    logic [DATA_W-1:0]        key_time = '0;
    logic signed [DATA_W-1:0] key_x = '0;
    logic signed [DATA_W-1:0] key_y = '0;
    logic signed [DATA_W-1:0] key_z = '0;
    logic [DATA_W-1:0]        query_time = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic [SLOT_W-1:0]        segment;
    logic [STAT_W-1:0]        status;

    track_checker track_chk = new();
    int send_calm = 0;
    int sink_calm = 0;

    keyframe_track_interpolator i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_key_count (cfg_key_count),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (command),
        .i_key_slot      (key_slot),
        .i_key_time      (key_time),
        .i_key_x         (key_x),
        .i_key_y         (key_y),
        .i_key_z         (key_z),
        .i_query_time    (query_time),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_out_x         (out_x),
        .o_out_y         (out_y),
        .o_out_z         (out_z),
        .o_segment       (segment),
        .o_status        (status)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 19))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd_word make_write(logic [SLOT_W-1:0] slot, logic [DATA_W-1:0] t,
                                             logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                                             logic [DATA_W-1:0] z);
        t_cmd_word w;
        w.command = CMD_WRITE;
        w.key_slot = slot;
        w.key_time = t;
        w.key_x = x;
        w.key_y = y;
        w.key_z = z;
        w.query_time = $urandom;
        return w;
    endfunction

    function automatic t_cmd_word make_query(logic [DATA_W-1:0] q);
        t_cmd_word w;
        w = make_write(SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom);
        w.command = CMD_QUERY;
        w.query_time = q;
        return w;
    endfunction

    function automatic t_cmd_word rand_query(int n);
        int k;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] q;
        k = $urandom_range(0, n - 1);
        lo = track_chk.time_mem[k];
        case ($urandom_range(0, 9))
            0: q = $urandom;
            1: q = lo;
            2: q = lo - 1;
            3: q = lo + 1;
            default: begin
                hi = (k + 1 < n) ? track_chk.time_mem[k+1] : lo;
                q = (hi > lo) ? lo + ($urandom % (hi - lo)) : lo + $urandom_range(0, 255);
            end
        endcase
        return make_query(q);
    endfunction

    // half of the rewrites inside the track keep the old time so the order holds
    function automatic t_cmd_word rand_write(int n);
        int slot;
        logic [DATA_W-1:0] t;
        slot = $urandom_range(0, MAX_KEYS - 1);
        t = (slot < n && $urandom_range(0, 1) == 1) ? track_chk.time_mem[slot] : $urandom;
        return make_write(SLOT_W'(slot), t, rand_value(), rand_value(), rand_value());
    endfunction

    task automatic send_word(t_cmd_word w);
        int gap;
        gap = draw_idle(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= w.command;
        key_slot   <= w.key_slot;
        key_time   <= w.key_time;
        key_x      <= w.key_x;
        key_y      <= w.key_y;
        key_z      <= w.key_z;
        query_time <= w.query_time;
        do @(posedge clk); while (!in_ready);
        track_chk.note_command(w);
    endtask

    task automatic write_key_count(logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (track_chk.owed_samples.size() != 0) @(posedge clk);
        cfg_valid     <= 1'b1;
        cfg_key_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        track_chk.key_count = value;
    endtask

    task automatic fill_track(int n);
        logic [32:0] t;
        logic [DATA_W-1:0] step_max;
        bit sorted;
        sorted = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 2))
            0: step_max = 32'd16;
            1: step_max = 32'h0001_0000;
            default: step_max = 32'h0400_0000;
        endcase
        t = ($urandom_range(0, 3) == 0) ? 33'd0 : 33'($urandom_range(0, 32'h0100_0000));
        for (int k = 0; k < n; k++) begin
            send_word(make_write(SLOT_W'(k), sorted ? t[DATA_W-1:0] : $urandom,
                                 rand_value(), rand_value(), rand_value()));
            t = t + $urandom_range(1, step_max);
            if (t > 33'hFFFF_FFFF) t = 33'hFFFF_FFFF;
        end
    endtask

    initial begin : stimulus
        int phase_counts [9];
        int n;
        phase_counts = '{64, 2, 127, 1, 65, 0, 17, 0, 0};
        phase_counts[7] = $urandom_range(3, 63);
        phase_counts[8] = $urandom_range(3, 63);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // one key in use after reset
        send_word(make_write(SLOT_W'(0), 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        send_word(make_query(32'h0));
        send_word(make_query(32'hFFFF_FFFF));
        write_key_count(CFG_W'(0));
        send_word(make_query(32'h5));
        write_key_count(CFG_W'(4));
        send_word(make_write(SLOT_W'(1), 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'hFFFF_FFFF));
        send_word(make_write(SLOT_W'(2), 32'h0002_0001, 32'h0, 32'h0, 32'h7FFF_FFFF));
        send_word(make_write(SLOT_W'(3), 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000));
        send_word(make_query(32'h0));
        send_word(make_query(32'h0000_FFFF));
        send_word(make_query(32'h0001_0000));
        send_word(make_query(32'h0001_8000));
        send_word(make_query(32'h0001_FFFF));
        send_word(make_query(32'h0002_0000));
        send_word(make_query(32'h0002_0001));
        send_word(make_query(32'hFFFF_FFFE));
        send_word(make_query(32'hFFFF_FFFF));
        // out-of-order key times
        send_word(make_write(SLOT_W'(2), 32'h0000_8000, 32'h1234_5678, 32'hFEDC_BA98, 32'h0));
        send_word(make_query(32'h0001_8000));
        send_word(make_query(32'h0003_0000));
        send_word(make_query(32'h0000_9000));

        foreach (phase_counts[p]) begin
            write_key_count(CFG_W'(phase_counts[p]));
            n = track_chk.keys_in_use();
            fill_track(n);
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 3) == 0) send_word(rand_write(n));
                else send_word(rand_query(n));
            end
        end

        in_valid <= 1'b0;
        while (track_chk.owed_samples.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (track_chk.failures == 0 && track_chk.owed_samples.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : result_sink
        int stall;
        int checked;
        t_sample got;
        checked = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            // long hold-off once, so the input side backs up
            stall = (checked == 150) ? 400 : draw_idle(sink_calm);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.x = out_x;
            got.y = out_y;
            got.z = out_z;
            got.segment = segment;
            got.status = status;
            track_chk.check_sample(got);
            checked++;
        end
    end

endmodule

>>> sim.f
rtl/kti_pkg.sv
rtl/kti_ram.sv
rtl/keyframe_track_interpolator.sv
verif/tb.sv
